// File: sv/hsv_color_adjust_blend_macros.svh
// assertion macros for the hsv color adjust and blend block
`ifndef HSV_COLOR_ADJUST_BLEND_MACROS_SVH
`define HSV_COLOR_ADJUST_BLEND_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while rst_n is low
`define HSVAB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HSVAB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HSVAB_ASSERT_IMP(lbl, ante, cons, msg)
`define HSVAB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/hsvab_pkg.sv
// shared types and constants of the hsv color adjust and blend block
`timescale 1ns / 1ps
`default_nettype none

package hsvab_pkg;

    // hue units: 1/256 of a tenth of a degree
    localparam int SECTOR_UNITS = 153600;
    localparam int CIRCLE_UNITS = 921600;

    // configuration register indexes
    localparam logic [1:0] REG_HUE_SHIFT  = 2'd0;
    localparam logic [1:0] REG_SAT_GAIN   = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

    typedef logic [2:0] sector_t;

    // hue sectors of 60 degrees
    localparam sector_t SEC_RED_YEL = 3'd0;
    localparam sector_t SEC_YEL_GRN = 3'd1;
    localparam sector_t SEC_GRN_CYN = 3'd2;
    localparam sector_t SEC_CYN_BLU = 3'd3;
    localparam sector_t SEC_BLU_MAG = 3'd4;
    localparam sector_t SEC_MAG_RED = 3'd5;

    // divider shapes
    localparam int FDIV_DW = 36;
    localparam int FDIV_SW = 9;
    localparam int FDIV_QW = 27;

    // secondary component divide: sector size is 2^11 * 75, so shift by 11
    // then multiply by the rounded-up reciprocal of 75 scaled by 2^38
    localparam int XDIV_DW = 42;
    localparam int X_SHIFT = 11;
    localparam int X_RSH   = 38;
    localparam logic [31:0] X_RECIP = 32'd3665038760;

    // pixel context before the hue and chroma divisions
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] weight;
        logic [7:0] val;
        logic [7:0] hi;
        logic [7:0] delta;
        sector_t    base;
        logic       dpos;
    } front_t;

    // pixel context around the secondary component division
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  weight;
        logic [7:0]  val;
        sector_t     sector;
        logic [23:0] chroma;
    } back_t;

endpackage

`default_nettype wire

// File: sv/hsvab_div.sv
// pipelined restoring divider, one quotient bit per stage, with a side payload
`timescale 1ns / 1ps
`default_nettype none

module hsvab_div #(
    parameter int DW = 36,
    parameter int SW = 9,
    parameter int QW = 27,
    parameter int PW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ce,
    input  wire logic          in_vld,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [SW-1:0] divisor,
    input  wire logic [PW-1:0] pay_in,
    output logic               out_vld,
    output logic [QW-1:0]      quotient,
    output logic [PW-1:0]      pay_out
);

    localparam int TW = (DW > SW + QW) ? DW : SW + QW;

    logic [DW-1:0] rem_reg [QW];
    logic [SW-1:0] dv_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic          vld_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int B = QW - 1 - i;

        logic [DW-1:0] rem_in;
        logic [SW-1:0] dv_in;
        logic [QW-1:0] q_in;
        logic          vld_in;
        logic [PW-1:0] pay_i;
        logic [TW-1:0] sh;
        logic [TW-1:0] rem_w;
        logic          fit;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign dv_in  = divisor;
            assign q_in   = '0;
            assign vld_in = in_vld;
            assign pay_i  = pay_in;
        end
        else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign dv_in  = dv_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign vld_in = vld_reg[i-1];
            assign pay_i  = pay_reg[i-1];
        end

        assign sh       = TW'(dv_in) << B;
        assign rem_w    = TW'(rem_in);
        assign fit      = rem_w >= sh;
        assign rem_next = fit ? DW'(rem_w - sh) : rem_in;
        assign q_next   = q_in | (QW'(fit) << B);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i] <= rem_next;
                dv_reg[i]  <= dv_in;
                q_reg[i]   <= q_next;
                pay_reg[i] <= pay_i;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quotient = q_reg[QW-1];
    assign pay_out  = pay_reg[QW-1];

endmodule

`default_nettype wire

// File: sv/hsv_color_adjust_blend.sv
// top level of the hsv hue, saturation and value adjust with per-pixel blend
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_color_adjust_blend_macros.svh"

// One RGB pixel with a blend weight goes in per transfer, one adjusted pixel
// comes out per transfer, in order. The block takes a new pixel every clock
// while the output register is empty or being taken. The pipeline is a
// 27-stage bit-per-stage divider pair that forms the hue within its
// sector and the scaled chroma side by side, one stage that forms the
// secondary color component by a shift and a reciprocal multiply, plus
// eleven plain stages around them. The whole pipeline advances together
// whenever the output register is empty or being taken, so s_tready follows
// m_tready combinationally; while the output waits every stage holds,
// empty slots included. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while no pixel is in flight.

module hsv_color_adjust_blend
    import hsvab_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // pixel in: red [7:0], green [15:8], blue [23:16], blend_weight [32:24]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // pixel out: red [7:0], green [15:8], blue [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    // pixel_changed [0]
    output logic [0:0]       m_tuser,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    // global pipeline advance
    logic adv;

    // configuration
    logic [12:0] hs_reg;
    logic [10:0] gain_reg;
    logic [8:0]  bo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg   <= 13'd0;
            gain_reg <= 11'd256;
            bo_reg   <= 9'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HUE_SHIFT:  hs_reg   <= cfg_data;
                REG_SAT_GAIN:   gain_reg <= cfg_data[10:0];
                REG_BRIGHTNESS: bo_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // valid bits of the plain stages
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic vld5_reg, vld6_reg, vld7_reg, vld8_reg;
    logic vld9_reg, vld10_reg, vld11_reg;
    logic xvld_reg;

    // divider outputs
    logic               hvld, cvld;
    logic [FDIV_QW-1:0] hq, cq;
    front_t             fd;
    logic [7:0]         cval;
    back_t              bk;

    assign adv      = !vld11_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg  <= 1'b0;
            vld2_reg  <= 1'b0;
            vld3_reg  <= 1'b0;
            vld4_reg  <= 1'b0;
            vld5_reg  <= 1'b0;
            vld6_reg  <= 1'b0;
            vld7_reg  <= 1'b0;
            vld8_reg  <= 1'b0;
            xvld_reg  <= 1'b0;
            vld9_reg  <= 1'b0;
            vld10_reg <= 1'b0;
            vld11_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg  <= s_tvalid;
            vld2_reg  <= vld1_reg;
            vld3_reg  <= vld2_reg;
            vld4_reg  <= vld3_reg;
            vld5_reg  <= hvld;
            vld6_reg  <= vld5_reg;
            vld7_reg  <= vld6_reg;
            vld8_reg  <= vld7_reg;
            xvld_reg  <= vld8_reg;
            vld9_reg  <= xvld_reg;
            vld10_reg <= vld9_reg;
            vld11_reg <= vld10_reg;
        end
    end

    // stage 1: input register, loaded on each input transfer slot
    logic [7:0] r1_reg, g1_reg, b1_reg;
    logic [8:0] w1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= s_tdata[7:0];
            g1_reg <= s_tdata[15:8];
            b1_reg <= s_tdata[23:16];
            w1_reg <= s_tdata[32:24];
        end
    end

    // stage 2: max, min, sector base, value with brightness
    front_t             f2_next, f2_reg;
    logic [8:0]         nd2_next, nd2_reg;
    logic [7:0]         hi2, lo2;
    logic signed [10:0] vsum2;

    always_comb
    begin
        hi2 = r1_reg;
        lo2 = r1_reg;
        if (g1_reg > hi2) hi2 = g1_reg;
        if (b1_reg > hi2) hi2 = b1_reg;
        if (g1_reg < lo2) lo2 = g1_reg;
        if (b1_reg < lo2) lo2 = b1_reg;

        f2_next.red    = r1_reg;
        f2_next.green  = g1_reg;
        f2_next.blue   = b1_reg;
        f2_next.weight = (w1_reg > 9'd256) ? 9'd256 : w1_reg;
        f2_next.hi     = hi2;
        f2_next.delta  = hi2 - lo2;
        f2_next.dpos   = hi2 != lo2;

        // num + delta stays in 0..2*delta, so 9 bits hold it
        priority if (r1_reg == hi2)
        begin
            f2_next.base = SEC_RED_YEL;
            nd2_next = 9'(10'(hi2 - lo2) + 10'(g1_reg) - 10'(b1_reg));
        end
        else if (g1_reg == hi2)
        begin
            f2_next.base = SEC_GRN_CYN;
            nd2_next = 9'(10'(hi2 - lo2) + 10'(b1_reg) - 10'(r1_reg));
        end
        else
        begin
            f2_next.base = SEC_BLU_MAG;
            nd2_next = 9'(10'(hi2 - lo2) + 10'(r1_reg) - 10'(g1_reg));
        end

        vsum2 = $signed({3'b000, hi2}) + 11'($signed(bo_reg));
        priority if (vsum2 < 0)
            f2_next.val = 8'd0;
        else if (vsum2 > 11'sd255)
            f2_next.val = 8'd255;
        else
            f2_next.val = vsum2[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg  <= f2_next;
            nd2_reg <= nd2_next;
        end
    end

    // stage 3: hue dividend and value times delta
    front_t      f3_reg;
    logic [26:0] hdiv3_reg;
    logic [15:0] vd3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg    <= f2_reg;
            hdiv3_reg <= 27'(nd2_reg * 27'(SECTOR_UNITS)) + 27'(f2_reg.delta >> 1);
            vd3_reg   <= f2_reg.val * f2_reg.delta;
        end
    end

    // stage 4: chroma dividend, 2*v*delta*gain*256 + hi over 2*hi
    front_t              f4_reg;
    logic [26:0]         hdiv4_reg;
    logic [FDIV_DW-1:0]  cdiv4_reg;
    logic [26:0]         cprod3;

    assign cprod3 = 27'(vd3_reg * gain_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f4_reg    <= f3_reg;
            hdiv4_reg <= hdiv3_reg;
            cdiv4_reg <= {cprod3, 9'b0} + FDIV_DW'(f3_reg.hi);
        end
    end

    // hue within sector and chroma, run in lockstep
    logic [$bits(front_t)-1:0] fd_bits;

    hsvab_div #(
        .DW (FDIV_DW),
        .SW (FDIV_SW),
        .QW (FDIV_QW),
        .PW ($bits(front_t))
    ) u_hue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (adv),
        .in_vld   (vld4_reg),
        .dividend (FDIV_DW'(hdiv4_reg)),
        .divisor  (FDIV_SW'(f4_reg.delta)),
        .pay_in   (f4_reg),
        .out_vld  (hvld),
        .quotient (hq),
        .pay_out  (fd_bits)
    );

    assign fd = front_t'(fd_bits);

    hsvab_div #(
        .DW (FDIV_DW),
        .SW (FDIV_SW),
        .QW (FDIV_QW),
        .PW (8)
    ) u_chroma_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (adv),
        .in_vld   (vld4_reg),
        .dividend (cdiv4_reg),
        .divisor  ({f4_reg.hi, 1'b0}),
        .pay_in   (f4_reg.val),
        .out_vld  (cvld),
        .quotient (cq),
        .pay_out  (cval)
    );

    // stage 5: absolute hue plus shift and two turns, chroma limit
    front_t      pix5_reg;
    logic [21:0] h5_next, h5_reg;
    logic [23:0] c5_next, c5_reg;
    logic [21:0] hpart5;
    logic [23:0] cmax5;

    always_comb
    begin
        hpart5 = fd.dpos ? (22'(fd.base) * 22'(SECTOR_UNITS) + 22'(hq)
                            - 22'(SECTOR_UNITS)) : 22'd0;
        // result is known to lie in 0..4 turns, so 22-bit wraparound is exact
        h5_next = 22'(2 * CIRCLE_UNITS) + hpart5 + {hs_reg[12], hs_reg, 8'b0};
        cmax5 = {cval, 16'b0};
        priority if (fd.hi == 8'd0)
            c5_next = 24'd0;
        else if (hq > FDIV_QW'(0) && cq > FDIV_QW'(cmax5))
            c5_next = cmax5;
        else if (cq > FDIV_QW'(cmax5))
            c5_next = cmax5;
        else
            c5_next = cq[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix5_reg <= fd;
            h5_reg   <= h5_next;
            c5_reg   <= c5_next;
        end
    end

    // stage 6: wrap hue into one turn
    front_t      pix6_reg;
    logic [19:0] h6_next, h6_reg;
    logic [23:0] c6_reg;

    always_comb
    begin
        priority if (h5_reg >= 22'(3 * CIRCLE_UNITS))
            h6_next = 20'(h5_reg - 22'(3 * CIRCLE_UNITS));
        else if (h5_reg >= 22'(2 * CIRCLE_UNITS))
            h6_next = 20'(h5_reg - 22'(2 * CIRCLE_UNITS));
        else if (h5_reg >= 22'(CIRCLE_UNITS))
            h6_next = 20'(h5_reg - 22'(CIRCLE_UNITS));
        else
            h6_next = h5_reg[19:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix6_reg <= pix5_reg;
            h6_reg   <= h6_next;
            c6_reg   <= c5_reg;
        end
    end

    // stage 7: sector and position inside it, mirrored in odd sectors
    front_t      pix7_reg;
    sector_t     sec7_next, sec7_reg;
    logic [17:0] f7_next, f7_reg;
    logic [23:0] c7_reg;
    logic [19:0] sbase7;
    logic [17:0] frac7;

    always_comb
    begin
        priority if (h6_reg >= 20'(5 * SECTOR_UNITS))
        begin
            sec7_next = SEC_MAG_RED;
            sbase7    = 20'(5 * SECTOR_UNITS);
        end
        else if (h6_reg >= 20'(4 * SECTOR_UNITS))
        begin
            sec7_next = SEC_BLU_MAG;
            sbase7    = 20'(4 * SECTOR_UNITS);
        end
        else if (h6_reg >= 20'(3 * SECTOR_UNITS))
        begin
            sec7_next = SEC_CYN_BLU;
            sbase7    = 20'(3 * SECTOR_UNITS);
        end
        else if (h6_reg >= 20'(2 * SECTOR_UNITS))
        begin
            sec7_next = SEC_GRN_CYN;
            sbase7    = 20'(2 * SECTOR_UNITS);
        end
        else if (h6_reg >= 20'(SECTOR_UNITS))
        begin
            sec7_next = SEC_YEL_GRN;
            sbase7    = 20'(SECTOR_UNITS);
        end
        else
        begin
            sec7_next = SEC_RED_YEL;
            sbase7    = 20'd0;
        end
        frac7   = 18'(h6_reg - sbase7);
        f7_next = sec7_next[0] ? 18'(SECTOR_UNITS) - frac7 : frac7;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix7_reg <= pix6_reg;
            sec7_reg <= sec7_next;
            f7_reg   <= f7_next;
            c7_reg   <= c6_reg;
        end
    end

    // stage 8: chroma times position, plus half a sector for rounding
    back_t               b8_reg;
    logic [XDIV_DW-1:0]  p8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b8_reg.red    <= pix7_reg.red;
            b8_reg.green  <= pix7_reg.green;
            b8_reg.blue   <= pix7_reg.blue;
            b8_reg.weight <= pix7_reg.weight;
            b8_reg.val    <= pix7_reg.val;
            b8_reg.sector <= sec7_reg;
            b8_reg.chroma <= c7_reg;
            p8_reg        <= XDIV_DW'(c7_reg * f7_reg) + XDIV_DW'(SECTOR_UNITS / 2);
        end
    end

    // secondary component: the shift takes the power of two out of the sector
    // size, the reciprocal multiply divides by 75 exactly for this range
    back_t       bx_reg;
    logic [23:0] xq_reg;
    logic [62:0] xprod8;

    assign xprod8 = p8_reg[XDIV_DW-1:X_SHIFT] * X_RECIP;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bx_reg <= b8_reg;
            xq_reg <= xprod8[X_RSH +: 24];
        end
    end

    assign bk = bx_reg;

    // stage 9: adjusted channels minus source, in 1/65536 steps
    back_t              bk9_reg;
    logic signed [25:0] dr9_reg, dg9_reg, db9_reg;
    logic [23:0]        ar9, ag9, ab9, x9, mq9;

    always_comb
    begin
        x9  = xq_reg;
        mq9 = {bk.val, 16'b0} - bk.chroma;
        unique case (bk.sector)
            SEC_RED_YEL: begin ar9 = bk.chroma; ag9 = x9;        ab9 = 24'd0;     end
            SEC_YEL_GRN: begin ar9 = x9;        ag9 = bk.chroma; ab9 = 24'd0;     end
            SEC_GRN_CYN: begin ar9 = 24'd0;     ag9 = bk.chroma; ab9 = x9;        end
            SEC_CYN_BLU: begin ar9 = 24'd0;     ag9 = x9;        ab9 = bk.chroma; end
            SEC_BLU_MAG: begin ar9 = x9;        ag9 = 24'd0;     ab9 = bk.chroma; end
            default:     begin ar9 = bk.chroma; ag9 = 24'd0;     ab9 = x9;        end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk9_reg <= bk;
            dr9_reg <= $signed(26'(ar9) + 26'(mq9) - 26'({bk.red, 16'b0}));
            dg9_reg <= $signed(26'(ag9) + 26'(mq9) - 26'({bk.green, 16'b0}));
            db9_reg <= $signed(26'(ab9) + 26'(mq9) - 26'({bk.blue, 16'b0}));
        end
    end

    // stage 10: blend accumulators, src * 2^24 + weight * difference
    back_t              bk10_reg;
    logic signed [35:0] ar10_reg, ag10_reg, ab10_reg;
    logic signed [9:0]  ws9;
    logic signed [35:0] wr9, wg9, wb9;

    assign ws9 = $signed({1'b0, bk9_reg.weight});
    assign wr9 = ws9 * dr9_reg;
    assign wg9 = ws9 * dg9_reg;
    assign wb9 = ws9 * db9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk10_reg <= bk9_reg;
            ar10_reg <= $signed({4'b0, bk9_reg.red, 24'b0}) + wr9;
            ag10_reg <= $signed({4'b0, bk9_reg.green, 24'b0}) + wg9;
            ab10_reg <= $signed({4'b0, bk9_reg.blue, 24'b0}) + wb9;
        end
    end

    // stage 11: clamp, round half up, change flag; this is the output register
    logic [7:0] or10, og10, ob10;
    logic [7:0] ro_reg, go_reg, bo_out_reg;
    logic       chg_reg;

    function automatic logic [7:0] round_chan(input logic signed [35:0] acc);
        logic [31:0] cl;
        logic [31:0] rs;
        if (acc < 0)
            cl = 32'd0;
        else if (acc > $signed({4'b0, 8'd255, 24'b0}))
            cl = {8'd255, 24'b0};
        else
            cl = acc[31:0];
        rs = cl + 32'h0080_0000;
        return rs[31:24];
    endfunction

    assign or10 = round_chan(ar10_reg);
    assign og10 = round_chan(ag10_reg);
    assign ob10 = round_chan(ab10_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ro_reg     <= or10;
            go_reg     <= og10;
            bo_out_reg <= ob10;
            chg_reg    <= (or10 != bk10_reg.red) || (og10 != bk10_reg.green)
                          || (ob10 != bk10_reg.blue);
        end
    end

    assign m_tvalid   = vld11_reg;
    assign m_tdata    = {bo_out_reg, go_reg, ro_reg};
    assign m_tuser[0] = chg_reg;

    // the two front dividers must stay in step and carry the same pixel
    `HSVAB_ASSERT_IMP(a_div_lockstep, 1'b1, hvld == cvld, "front dividers out of step")
    `HSVAB_ASSERT_IMP(a_div_payload, hvld, cval == fd.val, "front divider payload mismatch")
    // wrapped hue within one turn, chroma within value, sector in range
    `HSVAB_ASSERT_IMP(a_hue_wrap, vld6_reg, h6_reg < 20'(CIRCLE_UNITS), "hue not wrapped")
    `HSVAB_ASSERT_IMP(a_chroma_lim, vld6_reg, c6_reg <= {pix6_reg.val, 16'b0},
        "chroma above value")
    `HSVAB_ASSERT_NXT(a_sector_rng, vld6_reg && adv, sec7_reg <= SEC_MAG_RED,
        "hue sector out of range")

endmodule

`default_nettype wire

// File: tb/sv/hsv_color_adjust_blend_tb.sv
// testbench of the hsv color adjust and blend block with self-checking scoreboard
`timescale 1ns / 1ps

module hsv_color_adjust_blend_tb
    import hsvab_pkg::*;
;

    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 450;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       changed;
    } pixel_res_t;

    // pixel adjust predictor plus the queue of pixels it still waits for
    class adjust_scoreboard;
        logic signed [12:0] hue_shift;
        logic [10:0]        sat_gain;
        logic signed [8:0]  bright;
        pixel_res_t         pending[$];
        int                 mismatches;
        int                 checked;

        function new();
            hue_shift = 13'sd0;
            sat_gain  = 11'd256;
            bright    = 9'sd0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            if (idx == REG_HUE_SHIFT)
                hue_shift = val;
            else if (idx == REG_SAT_GAIN)
                sat_gain = val[10:0];
            else if (idx == REG_BRIGHTNESS)
                bright = val[8:0];
        endfunction

        // work out the adjusted, blended pixel for one accepted input transfer
        function void note_pixel(logic [39:0] data);
            longint src[3];
            longint adj[3];
            longint hi, lo, delta, hue, v, frac, xq, mq, chroma, w, num, base;
            longint n, d, c, acc, o, top;
            int k, sector;
            pixel_res_t r;
            src[0] = data[7:0];
            src[1] = data[15:8];
            src[2] = data[23:16];
            w = data[32:24];
            if (w > 256) w = 256;
            hi = src[0]; lo = src[0];
            for (k = 1; k < 3; k++)
            begin
                if (src[k] > hi) hi = src[k];
                if (src[k] < lo) lo = src[k];
            end
            delta = hi - lo;
            hue = 0;
            if (delta > 0)
            begin
                if (hi == src[0]) begin base = 0; num = src[1] - src[2]; end
                else if (hi == src[1]) begin base = 2; num = src[2] - src[0]; end
                else begin base = 4; num = src[0] - src[1]; end
                hue = base * SECTOR_UNITS + ((num + delta) * SECTOR_UNITS + delta / 2) / delta
                      - SECTOR_UNITS;
            end
            hue = (hue + longint'(hue_shift) * 256 + 2 * CIRCLE_UNITS) % CIRCLE_UNITS;
            v = hi + longint'(bright);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            chroma = 0;
            if (hi > 0)
            begin
                n = v * delta * longint'(sat_gain) * 65536;
                d = hi * 256;
                c = (n + d / 2) / d;
                if (c > v * 65536) c = v * 65536;
                chroma = c;
            end
            sector = int'(hue / SECTOR_UNITS);
            frac = hue % SECTOR_UNITS;
            if (sector % 2 == 0)
                xq = (chroma * frac + SECTOR_UNITS / 2) / SECTOR_UNITS;
            else
                xq = (chroma * (SECTOR_UNITS - frac) + SECTOR_UNITS / 2) / SECTOR_UNITS;
            mq = v * 65536 - chroma;
            case (sector)
                0: begin adj[0] = chroma; adj[1] = xq; adj[2] = 0; end
                1: begin adj[0] = xq; adj[1] = chroma; adj[2] = 0; end
                2: begin adj[0] = 0; adj[1] = chroma; adj[2] = xq; end
                3: begin adj[0] = 0; adj[1] = xq; adj[2] = chroma; end
                4: begin adj[0] = xq; adj[1] = 0; adj[2] = chroma; end
                default: begin adj[0] = chroma; adj[1] = 0; adj[2] = xq; end
            endcase
            r.changed = 1'b0;
            top = longint'(255) << 24;
            for (k = 0; k < 3; k++)
            begin
                acc = src[k] * 65536 * 256 + w * (adj[k] + mq - src[k] * 65536);
                if (acc < 0) acc = 0;
                if (acc > top) acc = top;
                o = (acc + (longint'(1) << 23)) >>> 24;
                if (o != src[k]) r.changed = 1'b1;
                if (k == 0) r.red = o[7:0];
                else if (k == 1) r.green = o[7:0];
                else r.blue = o[7:0];
            end
            pending = {pending, r};
        endfunction

        function void check_pixel(logic [23:0] data, logic flag);
            pixel_res_t exp_r;
            bit bad;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output transfer rgb=%h flag=%b", data, flag);
                return;
            end
            exp_r = pending.pop_front();
            bad = (data[7:0] !== exp_r.red) || (data[15:8] !== exp_r.green)
                  || (data[23:16] !== exp_r.blue) || (flag !== exp_r.changed);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: pixel %0d expected r=%0d g=%0d b=%0d chg=%b,",
                              " got r=%0d g=%0d b=%0d chg=%b"},
                             checked, exp_r.red, exp_r.green, exp_r.blue, exp_r.changed,
                             data[7:0], data[15:8], data[23:16], flag);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    // idle percentages per side, changed between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int wdog = 0;
    int pixels_sent = 0;
    bit timed_out = 0;

    adjust_scoreboard sb = new();

    always #5 clk = ~clk;

    hsv_color_adjust_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // red [7:0], green [15:8], blue [23:16], weight [32:24]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // red [7:0], green [15:8], blue [23:16]
        .m_tuser   (m_tuser),   // pixel_changed [0]
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sample both transfers at the rising edge; watchdog counts quiet cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                wdog <= 0;
            else
                wdog <= wdog + 1;
        end
    end

    always @(posedge clk)
    begin
        if (wdog >= WDOG_MAX && !timed_out)
        begin
            timed_out = 1;
            $display("ERROR: watchdog expired, %0d pixels still pending", sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one pixel transfer, with random gaps before it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [8:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w, b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // register write while the pipeline is empty
    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(int hs, int gain, int br);
        write_reg(REG_HUE_SHIFT, 13'(hs));
        write_reg(REG_SAT_GAIN, 13'(gain));
        write_reg(REG_BRIGHTNESS, 13'(br));
    endtask

    // random weight: mostly in range, sometimes zero, full or above full
    function automatic logic [8:0] rand_weight();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 9'd0;
        if (sel == 1) return 9'd256;
        if (sel == 2) return 9'($urandom_range(511));
        return 9'($urandom_range(256));
    endfunction

    task automatic random_pixels(int count);
        logic [7:0] r, g, b, gray;
        for (int i = 0; i < count; i++)
        begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            if ($urandom_range(9) == 0)
            begin
                // gray, black or white pixel
                gray = ($urandom_range(1) == 0) ? 8'($urandom) : {8{$urandom_range(1) == 1}};
                r = gray; g = gray; b = gray;
            end
            send_pixel(r, g, b, rand_weight());
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset config, extremes and special cases
        send_send_directed();
        drain();

        // phase 1: sender idles little, receiver a lot
        send_idle_pct = 15; recv_idle_pct = 66;
        set_config(3600, 1024, 128);
        random_pixels(N_RANDOM / 6);
        drain();
        set_config(-3600, 0, -128);
        random_pixels(N_RANDOM / 6);
        drain();

        // phase 2: the other way round, including out-of-range register values
        send_idle_pct = 66; recv_idle_pct = 15;
        set_config(4095, 2047, 255);
        random_pixels(N_RANDOM / 6);
        drain();
        set_config(-4096, 300, -256);
        random_pixels(N_RANDOM / 6);
        drain();
        // index beyond the register list must be ignored
        write_reg(2'd3, 13'h1FFF);

        // phase 3: no idling at all
        send_idle_pct = 0; recv_idle_pct = 0;
        set_config(int'($urandom_range(7200)) - 3600, int'($urandom_range(1024)),
                   int'($urandom_range(256)) - 128);
        random_pixels(N_RANDOM / 6);
        drain();
        set_config(1234, 180, 40);
        random_pixels(N_RANDOM / 6);
        drain();

        $display("covered %0d pixels over directed cases and three idle phases", pixels_sent);
        $display("register settings included the hue, gain and brightness extremes");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // directed pixels: extremes, gray and black, each hue sector, weight cases
    task automatic send_send_directed();
        send_pixel(8'd0, 8'd0, 8'd0, 9'd256);         // black
        send_pixel(8'd255, 8'd255, 8'd255, 9'd256);   // white
        send_pixel(8'd128, 8'd128, 8'd128, 9'd256);   // gray
        send_pixel(8'd255, 8'd0, 8'd0, 9'd256);       // pure red
        send_pixel(8'd255, 8'd200, 8'd0, 9'd256);     // red max, green above blue
        send_pixel(8'd100, 8'd255, 8'd0, 9'd256);     // green max
        send_pixel(8'd0, 8'd255, 8'd180, 9'd256);
        send_pixel(8'd0, 8'd90, 8'd255, 9'd256);      // blue max
        send_pixel(8'd200, 8'd0, 8'd255, 9'd256);
        send_pixel(8'd255, 8'd0, 8'd77, 9'd256);      // magenta-red
        send_pixel(8'd17, 8'd99, 8'd230, 9'd0);       // zero weight
        send_pixel(8'd17, 8'd99, 8'd230, 9'd511);     // weight above full
        send_pixel(8'd17, 8'd99, 8'd230, 9'd128);
        send_pixel(8'd255, 8'd255, 8'd0, 9'd1);
        drain();
        set_config(3600, 1024, 128);
        send_pixel(8'd10, 8'd200, 8'd60, 9'd256);
        send_pixel(8'd1, 8'd0, 8'd0, 9'd256);
        drain();
        set_config(-3600, 0, -128);
        send_pixel(8'd10, 8'd200, 8'd60, 9'd256);
        send_pixel(8'd255, 8'd255, 8'd255, 9'd256);
        drain();
        set_config(900, 700, 50);                     // rotate 90 degrees
        send_pixel(8'd255, 8'd0, 8'd0, 9'd256);
        send_pixel(8'd30, 8'd60, 8'd90, 9'd200);
        drain();
        set_config(0, 256, 0);
    endtask

endmodule

// File: files.f
+incdir+sv
sv/hsvab_pkg.sv
sv/hsvab_div.sv
sv/hsv_color_adjust_blend.sv
tb/sv/hsv_color_adjust_blend_tb.sv
